/* rtl/core/sacd_pkg.sv */
// Shared types and constants of the set-associative LRU cache directory.
// Holds the request and response payloads and the default geometry.
// No dependencies.
package sacd_pkg;

  // Default geometry of the directory.
  localparam int unsigned NUM_SETS_DEF    = 64;
  localparam int unsigned WAYS_DEF        = 4;
  localparam int unsigned BLOCK_BYTES_DEF = 64;
  localparam int unsigned ADDR_BITS_DEF   = 32;

  // Fixed widths of the channel fields and of the per-set stamps.
  localparam int unsigned ADDR_FIELD_W = 32;
  localparam int unsigned WAY_FIELD_W  = 2;
  localparam int unsigned TAG_FIELD_W  = 20;
  localparam int unsigned STAMP_W      = 32;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic [ADDR_FIELD_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic                   hit;
    logic [WAY_FIELD_W-1:0] way_used;
    logic                   evicted;
    logic                   needs_writeback;
    logic [TAG_FIELD_W-1:0] victim_tag;
  } rsp_t;

endpackage

/* rtl/core/sacd_if.sv */
// Valid/ready channel interfaces for the cache directory requests and responses.
// Depends on sacd_pkg for the payload types.
interface sacd_req_if;
  logic            valid;
  logic            ready;
  sacd_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sacd_rsp_if;
  logic            valid;
  logic            ready;
  sacd_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/set_assoc_lru_cache_directory_top.sv */
// Top level of the set-associative LRU cache directory.
// Depends on sacd_pkg, sacd_req_if, sacd_rsp_if and sacd_lookup.
//
// Usage:
//   req_i carries one access (cmd, address); rsp_o carries one result per
//   access (hit, way_used, evicted, needs_writeback, victim_tag), in order.
//   A transfer happens at a rising edge with valid and ready both high.
//   The set row is read from the directory memory into a register at the
//   transfer; the lookup then runs on it and its result is registered in the
//   output register when the lookup stage advances.
//   Throughput: one access per cycle while rsp_o does not stall. Each set row
//   (all ways plus the set clock) is read at the transfer and written when the
//   lookup stage retires; the row being written is forwarded to a same-set read.
//   Reset clears one valid flag per set; a set that was never written reads as
//   all zero, so no clearing pass is needed and accesses are taken at once.
//   When rsp_o stalls, the finished result waits in the output register, one
//   more access is taken and held in the lookup stage, and then req_i.ready
//   drops until the output register drains.
module set_assoc_lru_cache_directory_top #(
  parameter int unsigned NUM_SETS    = sacd_pkg::NUM_SETS_DEF,
  parameter int unsigned WAYS        = sacd_pkg::WAYS_DEF,
  parameter int unsigned BLOCK_BYTES = sacd_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned ADDR_BITS   = sacd_pkg::ADDR_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sacd_req_if.sink          req_i,
  sacd_rsp_if.source        rsp_o
);
  import sacd_pkg::*;

  localparam int unsigned OFF_W  = $clog2(BLOCK_BYTES);
  localparam int unsigned SET_W  = $clog2(NUM_SETS);
  localparam int unsigned IDX_W  = (SET_W > 0) ? SET_W : 1;
  localparam int unsigned TAG_W  = ADDR_BITS - OFF_W - SET_W;
  localparam int unsigned LINE_W = 2 + TAG_W + STAMP_W;
  localparam int unsigned ROW_W  = WAYS * LINE_W + STAMP_W;

  logic [ADDR_BITS-1:0] addr_ext;
  logic [IDX_W-1:0]     set_idx;
  logic [TAG_W-1:0]     tag_in;
  logic                 accept;

  logic                 s1_valid_q, s1_valid_d;
  cmd_e                 s1_cmd_q;
  logic [IDX_W-1:0]     s1_set_q;
  logic [TAG_W-1:0]     s1_tag_q;
  logic                 s1_adv;

  logic [ROW_W-1:0]     mem_q [NUM_SETS];
  logic [ROW_W-1:0]     rd_row_q;
  logic                 rd_live_q;
  logic                 byp_q;
  logic [ROW_W-1:0]     byp_row_q;
  logic [NUM_SETS-1:0]  row_valid_q, row_valid_d;
  logic [ROW_W-1:0]     cur_row;
  logic [ROW_W-1:0]     wr_row;

  logic                 out_valid_q, out_valid_d;
  rsp_t                 rsp_q;
  rsp_t                 rsp_new;

  assign addr_ext = ADDR_BITS'(req_i.data.address);
  assign tag_in   = addr_ext[ADDR_BITS-1 -: TAG_W];

  if (SET_W > 0) begin : g_set_idx
    assign set_idx = addr_ext[OFF_W +: IDX_W];
  end else begin : g_one_set
    assign set_idx = '0;
  end

  assign accept      = req_i.valid && req_i.ready;
  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;

  // A row never written since reset reads as all zero.
  assign cur_row = byp_q ? byp_row_q : (rd_live_q ? rd_row_q : '0);

  sacd_lookup #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .ROW_W (ROW_W)
  ) u_lookup (
    .cmd_i (s1_cmd_q),
    .tag_i (s1_tag_q),
    .row_i (cur_row),
    .row_o (wr_row),
    .rsp_o (rsp_new)
  );

  // Directory memory: one row per set, read at the transfer, written when the
  // lookup stage retires.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem_q[s1_set_q] <= wr_row;
    end
    if (accept) begin
      rd_row_q <= mem_q[set_idx];
    end
  end

  // Lookup stage payload. The memory returns the old row when the same set is
  // written at the read edge, so the row being written is captured for forwarding.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q  <= req_i.data.cmd;
      s1_set_q  <= set_idx;
      s1_tag_q  <= tag_in;
      rd_live_q <= row_valid_q[set_idx];
      byp_q     <= s1_adv && (s1_set_q == set_idx);
      byp_row_q <= wr_row;
    end
    if (s1_adv) begin
      rsp_q <= rsp_new;
    end
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    row_valid_d = row_valid_q;
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      s1_valid_d            = 1'b0;
      row_valid_d[s1_set_q] = 1'b1;
      out_valid_d           = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = rsp_q;

endmodule

/* rtl/core/sacd_lookup.sv */
// Tag compare, victim choice and row update for one set of the directory.
// Purely combinational; depends on sacd_pkg.
module sacd_lookup #(
  parameter int unsigned WAYS  = sacd_pkg::WAYS_DEF,
  parameter int unsigned TAG_W = 20,
  parameter int unsigned ROW_W = WAYS * (2 + TAG_W + sacd_pkg::STAMP_W) + sacd_pkg::STAMP_W
) (
  input  sacd_pkg::cmd_e   cmd_i,
  input  logic [TAG_W-1:0] tag_i,
  input  logic [ROW_W-1:0] row_i,
  output logic [ROW_W-1:0] row_o,
  output sacd_pkg::rsp_t   rsp_o
);
  import sacd_pkg::*;

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef struct packed {
    logic [STAMP_W-1:0]    clock;
    line_t [WAYS-1:0]      lines;
  } row_t;

  row_t               cur_row;
  row_t               new_row;
  logic               hit;
  logic [WAY_W-1:0]   hit_way;
  logic               have_inv;
  logic [WAY_W-1:0]   inv_way;
  logic [WAY_W-1:0]   lru_way;
  logic [STAMP_W-1:0] lru_stamp;
  logic [WAY_W-1:0]   victim_way;
  logic [WAY_W-1:0]   way;
  logic [STAMP_W-1:0] next_clock;
  line_t              victim_line;
  logic               is_write;

  assign cur_row  = row_t'(row_i);
  assign is_write = (cmd_i == CMD_WRITE);

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    have_inv  = 1'b0;
    inv_way   = '0;
    lru_way   = '0;
    lru_stamp = cur_row.lines[0].stamp;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && cur_row.lines[w].valid && cur_row.lines[w].tag == tag_i) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      // The last invalid way seen is the highest-numbered one.
      if (!cur_row.lines[w].valid) begin
        have_inv = 1'b1;
        inv_way  = WAY_W'(w);
      end
      // Strict compare keeps the lowest-numbered way on a tie.
      if (cur_row.lines[w].stamp < lru_stamp) begin
        lru_stamp = cur_row.lines[w].stamp;
        lru_way   = WAY_W'(w);
      end
    end
  end

  assign victim_way  = have_inv ? inv_way : lru_way;
  assign way         = hit ? hit_way : victim_way;
  assign next_clock  = cur_row.clock + STAMP_W'(1);
  assign victim_line = cur_row.lines[victim_way];

  always_comb begin
    new_row                  = cur_row;
    new_row.clock            = next_clock;
    new_row.lines[way].stamp = next_clock;
    if (hit) begin
      new_row.lines[way].dirty = cur_row.lines[way].dirty | is_write;
    end else begin
      new_row.lines[way].valid = 1'b1;
      new_row.lines[way].dirty = is_write;
      new_row.lines[way].tag   = tag_i;
    end
  end

  assign row_o = ROW_W'(new_row);

  always_comb begin
    rsp_o                 = '0;
    rsp_o.hit             = hit;
    rsp_o.way_used        = WAY_FIELD_W'(way);
    rsp_o.evicted         = !hit && victim_line.valid;
    rsp_o.needs_writeback = !hit && victim_line.valid && victim_line.dirty;
    rsp_o.victim_tag      = (!hit && victim_line.valid) ? TAG_FIELD_W'(victim_line.tag) : '0;
  end

endmodule

/* bench/sacd_checker.sv */
// Response checker for the set-associative LRU cache directory.
// Watches the request and response channels, keeps its own copy of the directory
// and compares every result in order. Depends on sacd_pkg and the channel interfaces.
module sacd_checker (
  input  logic clk_i,
  input  logic rst_ni,
  sacd_req_if  req_mon,
  sacd_rsp_if  rsp_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import sacd_pkg::*;

  localparam int unsigned SETS  = NUM_SETS_DEF;
  localparam int unsigned NWAYS = WAYS_DEF;
  localparam int unsigned LINES = SETS * NWAYS;
  localparam int unsigned OFS_W = $clog2(BLOCK_BYTES_DEF);
  localparam int unsigned SET_W = $clog2(NUM_SETS_DEF);

  logic                   line_ok    [LINES];
  logic                   line_wb    [LINES];
  logic [TAG_FIELD_W-1:0] line_label [LINES];
  logic [STAMP_W-1:0]     line_age   [LINES];
  logic [STAMP_W-1:0]     set_tick   [SETS];

  rsp_t expected_rsp_q[$];
  int   rsp_seen;

  // Looks the access up in the directory copy, updates it and returns the result.
  function automatic rsp_t lookup_and_fill(req_t acc);
    int unsigned            set_no;
    int unsigned            base;
    int unsigned            victim;
    logic [TAG_FIELD_W-1:0] tg;
    bit                     found_free;
    rsp_t                   r;
    set_no = 32'(acc.address[OFS_W +: SET_W]);
    tg     = acc.address[ADDR_FIELD_W-1 : OFS_W+SET_W];
    base   = set_no * NWAYS;
    r      = '0;
    for (int unsigned w = 0; w < NWAYS; w++) begin
      if (line_ok[base+w] && line_label[base+w] == tg) begin
        set_tick[set_no]  = set_tick[set_no] + 1;
        line_age[base+w]  = set_tick[set_no];
        if (acc.cmd == CMD_WRITE) line_wb[base+w] = 1'b1;
        r.hit      = 1'b1;
        r.way_used = WAY_FIELD_W'(w);
        return r;
      end
    end
    // Miss: the highest free way wins, else the oldest stamp, lowest way on a tie.
    found_free = 1'b0;
    victim     = 0;
    for (int unsigned w = 0; w < NWAYS; w++) begin
      if (!line_ok[base+w]) begin
        victim     = w;
        found_free = 1'b1;
      end
    end
    if (!found_free) begin
      for (int unsigned w = 1; w < NWAYS; w++) begin
        if (line_age[base+w] < line_age[base+victim]) victim = w;
      end
    end
    r.way_used        = WAY_FIELD_W'(victim);
    r.evicted         = line_ok[base+victim];
    r.needs_writeback = line_ok[base+victim] && line_wb[base+victim];
    r.victim_tag      = line_ok[base+victim] ? line_label[base+victim] : '0;
    set_tick[set_no]       = set_tick[set_no] + 1;
    line_ok[base+victim]    = 1'b1;
    line_wb[base+victim]    = (acc.cmd == CMD_WRITE);
    line_label[base+victim] = tg;
    line_age[base+victim]   = set_tick[set_no];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("tb: mismatch on result %0d, %s: expected %h, got %h",
             rsp_seen, what, exp_v, got_v);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    rsp_t got;
    if (!rst_ni) begin
      for (int i = 0; i < LINES; i++) begin
        line_ok[i]    = 1'b0;
        line_wb[i]    = 1'b0;
        line_label[i] = '0;
        line_age[i]   = '0;
      end
      for (int s = 0; s < SETS; s++) set_tick[s] = '0;
      expected_rsp_q.delete();
      rsp_seen     = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        expected_rsp_q.push_back(lookup_and_fill(req_mon.data));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.data;
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result with no access waiting", '0, 32'(got));
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.hit !== want.hit)
            report_mismatch("hit", 32'(want.hit), 32'(got.hit));
          if (got.way_used !== want.way_used)
            report_mismatch("way_used", 32'(want.way_used), 32'(got.way_used));
          if (got.evicted !== want.evicted)
            report_mismatch("evicted", 32'(want.evicted), 32'(got.evicted));
          if (got.needs_writeback !== want.needs_writeback)
            report_mismatch("needs_writeback", 32'(want.needs_writeback),
                            32'(got.needs_writeback));
          if (got.victim_tag !== want.victim_tag)
            report_mismatch("victim_tag", 32'(want.victim_tag), 32'(got.victim_tag));
        end
        rsp_seen++;
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// Top of the cache directory testbench: clock, reset, stimulus and verdict.
// Depends on sacd_pkg, the channel interfaces, the directory top and sacd_checker.
module tb_top;
  import sacd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 300;   // per phase

  logic clk_i;
  logic rst_ni = 1'b0;

  sacd_req_if req_if ();
  sacd_rsp_if rsp_if ();

  int fail_count;
  int pending;
  int cycle_count    = 0;
  int sender_idle_pct = 27;
  int sink_stall_pct  = 80;

  logic [TAG_FIELD_W-1:0] tag_pool [8];
  logic [5:0]             hot_set  [4];

  set_assoc_lru_cache_directory_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  sacd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  function automatic logic [ADDR_FIELD_W-1:0] line_address(logic [TAG_FIELD_W-1:0] tg,
                                                           logic [5:0] set_no);
    return {tg, set_no, 6'($urandom_range(0, 63))};
  endfunction

  // Offers one access and returns at the edge where it transfers.
  task automatic issue_access(input cmd_e c, input logic [ADDR_FIELD_W-1:0] a);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req_t'{cmd: c, address: a};
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic random_access();
    int   roll;
    cmd_e c;
    roll = $urandom_range(0, 99);
    c    = cmd_e'($urandom_range(0, 1));
    // Mostly a few busy sets with a tag pool a bit larger than the ways, so
    // that hits, LRU evictions and dirty write-backs all come up often.
    if (roll < 70)
      issue_access(c, line_address(tag_pool[$urandom_range(0, 5)],
                                   hot_set[$urandom_range(0, 3)]));
    else if (roll < 90)
      issue_access(c, line_address(tag_pool[$urandom_range(0, 7)],
                                   6'($urandom_range(0, 63))));
    else
      issue_access(c, $urandom);
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 8; i++) tag_pool[i] = TAG_FIELD_W'($urandom);
    hot_set[0] = 6'd0;
    hot_set[1] = 6'd63;
    hot_set[2] = 6'($urandom_range(1, 62));
    hot_set[3] = 6'($urandom_range(1, 62));
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill set 0 from the top way down, hit with a write and a read, then
    // push it through enough misses to evict every line, the dirty one too.
    for (int i = 0; i < 4; i++) issue_access(CMD_READ, line_address(tag_pool[i], 6'd0));
    issue_access(CMD_WRITE, line_address(tag_pool[2], 6'd0));
    issue_access(CMD_READ, line_address(tag_pool[0], 6'd0));
    for (int i = 4; i < 8; i++) issue_access(CMD_WRITE, line_address(tag_pool[i], 6'd0));
    issue_access(CMD_READ, line_address(tag_pool[2], 6'd0));
    // Address extremes: lowest and highest set, offset and tag.
    issue_access(CMD_READ, 32'h0000_0000);
    issue_access(CMD_WRITE, 32'hFFFF_FFFF);
    issue_access(CMD_READ, 32'hFFFF_FFC0);
    issue_access(CMD_WRITE, 32'h0000_003F);
    issue_access(CMD_READ, 32'hFFFF_F03F);
    for (int i = 0; i < 4; i++) issue_access(CMD_WRITE, line_address(tag_pool[i], 6'd63));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 27;
          sink_stall_pct  = 80;
        end
        1: begin
          sender_idle_pct = 80;
          sink_stall_pct  = 27;
        end
        default: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 0;
        end
      endcase
      repeat (RANDOM_ITEMS) random_access();
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
